// ----- rtl/sts_pkg.sv -----
// Shared widths, constants and controller/datapath handshake types for the
// Taylor-series sine block. Depends on nothing; every other file uses it.
package sts_pkg;

    // Maximum number of series terms, counting the leading x.
    localparam int MAX_TERMS = 16;

    // Port field widths.
    localparam int ANGLE_W  = 32;
    localparam int SINE_W   = 32;
    localparam int TCOUNT_W = 5;
    localparam int THRESH_W = 41;

    // Reset value of the stop threshold, about 0.0001 in Q.40.
    localparam logic [THRESH_W-1:0] THRESH_RESET = 41'd109951163;

    // Internal Q.40 widths. The largest term is below 2^49 for |x| <= 8.
    localparam int FRAC_SHIFT = 12;
    localparam int MAG_W      = 50;
    localparam int X2_W       = 47;
    localparam int SUM_W      = 56;

    // Width of the running sum after the shift back to Q3.28.
    localparam int SUM_SH_W   = SUM_W - FRAC_SHIFT;

    // Multiplier split into four partial products of at most 25 x 24 bits.
    localparam int MAG_LO_W = 25;
    localparam int MAG_HI_W = MAG_W - MAG_LO_W;
    localparam int X2_LO_W  = 24;
    localparam int X2_HI_W  = X2_W - X2_LO_W;
    localparam int PP_W     = MAG_LO_W + X2_LO_W + 1;
    localparam int ACC_W    = MAG_W + X2_W;
    localparam int MUL_PASSES = 4;
    localparam int MSTEP_W    = $clog2(MUL_PASSES + 2);

    // Divider: the product is taken >> 40, then divided 4 bits per cycle.
    localparam int QSHIFT     = 40;
    localparam int DIVR_BITS  = 4;
    localparam int DIVD_RAW_W = ACC_W - QSHIFT;
    localparam int DIV_STEPS  = (DIVD_RAW_W + DIVR_BITS - 1) / DIVR_BITS;
    localparam int DIVD_W     = DIV_STEPS * DIVR_BITS;
    localparam int DSTEP_W    = $clog2(DIV_STEPS + 1);

    // Term index i, term count and divisor (i+1)(i+2) widths.
    localparam int IDX_W   = $clog2(2 * MAX_TERMS);
    localparam int TERMS_W = $clog2(MAX_TERMS + 1);
    localparam int DIVS_W  = $clog2((2 * MAX_TERMS) * (2 * MAX_TERMS + 1) + 1);

    // Divisor for the first recurrence step, (1+1)(1+2).
    localparam logic [DIVS_W-1:0] FIRST_DIVISOR = DIVS_W'(6);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic init;
        logic mul_clear;
        logic mul_run;
        logic div_load;
        logic div_run;
        logic mag_load;
        logic accum;
        logic load_out;
    } sts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic first;
        logic mag_le_thr;
        logic terms_max;
    } sts_status_t;

endpackage

// ----- rtl/sts_if.sv -----
// Valid/ready channel interfaces for the angle input and the sine result.
// Depends on sts_pkg for field widths.
interface sts_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [sts_pkg::ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface sts_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sts_pkg::SINE_W-1:0]   sine;
    logic        [sts_pkg::TCOUNT_W-1:0] terms_used;
    logic                               truncated;

    modport source (output valid, output sine, output terms_used, output truncated,
                    input ready);
    modport sink   (input valid, input sine, input terms_used, input truncated,
                    output ready);
endinterface

// ----- rtl/sts_dp.sv -----
// Datapath of the Taylor-series sine: term recurrence with a multi-pass
// multiplier, a radix-16 restoring divider, the running sum and result register.
// Depends on sts_pkg.
module sts_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sts_pkg::sts_cmd_t                    cmd,
    output sts_pkg::sts_status_t                 status,
    input  logic signed [sts_pkg::ANGLE_W-1:0]   angle,
    input  logic                                 cfg_wr_en,
    input  logic        [sts_pkg::THRESH_W-1:0]  cfg_wr_data,
    output logic signed [sts_pkg::SINE_W-1:0]    sine,
    output logic        [sts_pkg::TCOUNT_W-1:0]  terms_used,
    output logic                                 truncated
);

    // Stop threshold register.
    logic [sts_pkg::THRESH_W-1:0] thr_reg;

    // Operand and recurrence state.
    logic                           neg_reg;
    logic [sts_pkg::ANGLE_W-1:0]    ax_reg;
    logic [sts_pkg::X2_W-1:0]       x2_reg;
    logic [sts_pkg::MAG_W-1:0]      mag_reg;
    logic signed [sts_pkg::SUM_W-1:0] sum_reg;
    logic [sts_pkg::IDX_W-1:0]      idx_reg;
    logic [sts_pkg::DIVS_W-1:0]     divisor_reg;
    logic [sts_pkg::TERMS_W-1:0]    terms_reg;
    logic                           first_reg;

    // Multiplier state.
    logic [sts_pkg::MSTEP_W-1:0]    mstep_reg;
    logic [sts_pkg::PP_W-1:0]       pp_reg;
    logic [sts_pkg::ACC_W-1:0]      acc_reg;

    // Divider state.
    logic [sts_pkg::DSTEP_W-1:0]    dstep_reg;
    logic [sts_pkg::DIVD_W-1:0]     divq_reg;
    logic [sts_pkg::DIVS_W-1:0]     rem_reg;

    // Result registers.
    logic signed [sts_pkg::SINE_W-1:0]   sine_reg;
    logic        [sts_pkg::TCOUNT_W-1:0] terms_out_reg;
    logic                                trunc_reg;

    // Combinational helpers.
    logic [sts_pkg::ANGLE_W-1:0]    ax_next;
    logic [2*sts_pkg::ANGLE_W-1:0]  square;
    logic [sts_pkg::MAG_W-1:0]      mag_init;
    logic [sts_pkg::MAG_LO_W-1:0]   mul_a;
    logic [sts_pkg::X2_LO_W-1:0]    mul_b;
    logic [sts_pkg::PP_W-1:0]       pp_next;
    logic [1:0]                     pass_prev;
    logic [sts_pkg::ACC_W-1:0]      pp_shifted;
    logic [sts_pkg::DIVD_W-1:0]     divq_next;
    logic [sts_pkg::DIVS_W-1:0]     rem_next;
    logic [sts_pkg::IDX_W-1:0]      idx_next;
    logic [sts_pkg::IDX_W:0]        ip1;
    logic [sts_pkg::IDX_W:0]        ip2;
    logic signed [sts_pkg::SUM_W-1:0] mag_ext;
    logic                           term_neg;
    logic signed [sts_pkg::SUM_SH_W-1:0] sum_sh;
    logic                           sh_fits;
    logic signed [sts_pkg::SINE_W-1:0] sine_next;

    // Threshold register, written from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= sts_pkg::THRESH_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Magnitude of the angle and its square in Q.40.
    assign ax_next  = angle[sts_pkg::ANGLE_W-1] ? (~angle + 1'b1) : angle;
    assign square   = ax_reg * ax_reg;
    assign mag_init = sts_pkg::MAG_W'({ax_reg, {sts_pkg::FRAC_SHIFT{1'b0}}});

    // Operand selection for the four multiplier passes.
    always_comb
    begin
        unique case (mstep_reg[1:0])
            2'd0:
            begin
                mul_a = mag_reg[sts_pkg::MAG_LO_W-1:0];
                mul_b = x2_reg[sts_pkg::X2_LO_W-1:0];
            end
            2'd1:
            begin
                mul_a = mag_reg[sts_pkg::MAG_LO_W-1:0];
                mul_b = sts_pkg::X2_LO_W'(x2_reg[sts_pkg::X2_W-1:sts_pkg::X2_LO_W]);
            end
            2'd2:
            begin
                mul_a = sts_pkg::MAG_LO_W'(mag_reg[sts_pkg::MAG_W-1:sts_pkg::MAG_LO_W]);
                mul_b = x2_reg[sts_pkg::X2_LO_W-1:0];
            end
            default:
            begin
                mul_a = sts_pkg::MAG_LO_W'(mag_reg[sts_pkg::MAG_W-1:sts_pkg::MAG_LO_W]);
                mul_b = sts_pkg::X2_LO_W'(x2_reg[sts_pkg::X2_W-1:sts_pkg::X2_LO_W]);
            end
        endcase
    end

    assign pp_next   = sts_pkg::PP_W'(mul_a * mul_b);
    assign pass_prev = 2'(mstep_reg - 1'b1);

    // Weight of the registered partial product from the previous pass.
    always_comb
    begin
        unique case (pass_prev)
            2'd0:    pp_shifted = sts_pkg::ACC_W'(pp_reg);
            2'd1:    pp_shifted = sts_pkg::ACC_W'(pp_reg) << sts_pkg::X2_LO_W;
            2'd2:    pp_shifted = sts_pkg::ACC_W'(pp_reg) << sts_pkg::MAG_LO_W;
            default: pp_shifted = sts_pkg::ACC_W'(pp_reg)
                                  << (sts_pkg::MAG_LO_W + sts_pkg::X2_LO_W);
        endcase
    end

    // Four restoring division steps; the remainder stays below the divisor.
    always_comb
    begin
        logic [sts_pkg::DIVS_W:0] trial;
        divq_next = divq_reg;
        rem_next  = rem_reg;
        for (int k = 0; k < sts_pkg::DIVR_BITS; k++)
        begin
            trial     = {rem_next, divq_next[sts_pkg::DIVD_W-1]};
            divq_next = {divq_next[sts_pkg::DIVD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial        = trial - {1'b0, divisor_reg};
                divq_next[0] = 1'b1;
            end
            rem_next = trial[sts_pkg::DIVS_W-1:0];
        end
    end

    // Next term index, its divisor and the signed contribution of the term.
    assign idx_next = idx_reg + sts_pkg::IDX_W'(2);
    assign ip1      = {1'b0, idx_next} + 1'b1;
    assign ip2      = {1'b0, idx_next} + 2'd2;
    assign mag_ext  = $signed(sts_pkg::SUM_W'(mag_reg));
    assign term_neg = neg_reg ^ idx_next[1];

    // Floor shift back to Q3.28 and saturation.
    assign sum_sh  = sts_pkg::SUM_SH_W'(sum_reg >>> sts_pkg::FRAC_SHIFT);
    assign sh_fits = (&sum_sh[sts_pkg::SUM_SH_W-1:sts_pkg::SINE_W-1])
                     | ~(|sum_sh[sts_pkg::SUM_SH_W-1:sts_pkg::SINE_W-1]);

    always_comb
    begin
        if (sh_fits)
        begin
            sine_next = sum_sh[sts_pkg::SINE_W-1:0];
        end
        else
        begin
            sine_next = sum_sh[sts_pkg::SUM_SH_W-1] ? {1'b1, {(sts_pkg::SINE_W-1){1'b0}}}
                                                    : {1'b0, {(sts_pkg::SINE_W-1){1'b1}}};
        end
    end

    // Pass and step counters of the multiplier and divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mstep_reg <= '0;
            dstep_reg <= '0;
        end
        else
        begin
            if (cmd.mul_clear)
            begin
                mstep_reg <= '0;
            end
            else if (cmd.mul_run)
            begin
                mstep_reg <= mstep_reg + 1'b1;
            end
            if (cmd.div_load)
            begin
                dstep_reg <= '0;
            end
            else if (cmd.div_run)
            begin
                dstep_reg <= dstep_reg + 1'b1;
            end
        end
    end

    // Payload registers of the recurrence.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            neg_reg <= angle[sts_pkg::ANGLE_W-1];
            ax_reg  <= ax_next;
        end

        if (cmd.init)
        begin
            x2_reg      <= square[sts_pkg::X2_W+15:16];
            mag_reg     <= mag_init;
            sum_reg     <= neg_reg ? -$signed(sts_pkg::SUM_W'(mag_init))
                                   : $signed(sts_pkg::SUM_W'(mag_init));
            idx_reg     <= sts_pkg::IDX_W'(1);
            divisor_reg <= sts_pkg::FIRST_DIVISOR;
            terms_reg   <= sts_pkg::TERMS_W'(1);
            first_reg   <= 1'b1;
        end
        else if (cmd.accum)
        begin
            idx_reg     <= idx_next;
            divisor_reg <= sts_pkg::DIVS_W'(ip1) * sts_pkg::DIVS_W'(ip2);
            sum_reg     <= term_neg ? (sum_reg - mag_ext) : (sum_reg + mag_ext);
            terms_reg   <= terms_reg + 1'b1;
            first_reg   <= 1'b0;
        end
        else if (cmd.mag_load)
        begin
            mag_reg <= divq_reg[sts_pkg::MAG_W-1:0];
        end

        // Multiply: one partial product per pass, registered and accumulated on the following pass.
        if (cmd.mul_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mul_run)
        begin
            if (mstep_reg < sts_pkg::MSTEP_W'(sts_pkg::MUL_PASSES))
            begin
                pp_reg <= pp_next;
            end
            if (mstep_reg != '0)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end

        // Divide (product >> 40) by (i+1)(i+2).
        if (cmd.div_load)
        begin
            divq_reg <= sts_pkg::DIVD_W'(acc_reg[sts_pkg::ACC_W-1:sts_pkg::QSHIFT]);
            rem_reg  <= '0;
        end
        else if (cmd.div_run)
        begin
            divq_reg <= divq_next;
            rem_reg  <= rem_next;
        end

        // Result beat.
        if (cmd.load_out)
        begin
            sine_reg      <= sine_next;
            terms_out_reg <= sts_pkg::TCOUNT_W'(terms_reg);
            trunc_reg     <= ~status.mag_le_thr;
        end
    end

    // Status to the controller.
    assign status.mul_done   = (mstep_reg == sts_pkg::MSTEP_W'(sts_pkg::MUL_PASSES + 1));
    assign status.div_done   = (dstep_reg == sts_pkg::DSTEP_W'(sts_pkg::DIV_STEPS));
    assign status.first      = first_reg;
    assign status.mag_le_thr = (mag_reg <= sts_pkg::MAG_W'(thr_reg));
    assign status.terms_max  = (terms_reg >= sts_pkg::TERMS_W'(sts_pkg::MAX_TERMS));

    assign sine       = sine_reg;
    assign terms_used = terms_out_reg;
    assign truncated  = trunc_reg;

endmodule

// ----- rtl/sts_ctrl.sv -----
// Controller of the Taylor-series sine: sequences square, multiply, divide and
// accumulate steps per term and owns the channel handshakes. Depends on sts_pkg.
module sts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  sts_pkg::sts_status_t status,
    output sts_pkg::sts_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQUARE = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_CHECK  = 7'b0010000,
        ST_ACCUM  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } sts_state_t;

    sts_state_t state_reg;
    sts_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.init      = 1'b1;
                cmd.mul_clear = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                if (status.mul_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    cmd.mul_run = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.mag_load = 1'b1;
                    state_next   = ST_CHECK;
                end
                else
                begin
                    cmd.div_run = 1'b1;
                end
            end
            ST_CHECK:
            begin
                // The x^3 term is always added; later terms stop on threshold or cap.
                priority if (status.first)
                begin
                    state_next = ST_ACCUM;
                end
                else if (status.mag_le_thr || status.terms_max)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                cmd.accum     = 1'b1;
                cmd.mul_clear = 1'b1;
                state_next    = ST_MUL;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/sine_taylor_series.sv -----
// Top level of the Taylor-series sine block: controller plus datapath.
// Depends on sts_pkg, sts_if, sts_ctrl and sts_dp.

// Computes sin(x) for a signed Q3.28 angle by summing x - x^3/3! + x^5/5! - ...
// in Q15.40 and returns the sum floored and saturated to Q3.28, with the number
// of terms summed and a flag set when the term cap ended the series before the
// next term fell to or below stop_threshold. One angle is worked on at a time.
// Each term runs through the four-pass 25x24 multiplier, the radix-16 restoring
// divider by (i+1)(i+2), the check and the accumulate. The next angle is taken as
// soon as the result sits in the output register, even if it has not been taken
// yet.
// stop_threshold may be written only while no angle is in flight.
module sine_taylor_series (
    input  logic                                clk,
    input  logic                                rst_n,
    sts_in_if.sink                              in_ch,
    sts_out_if.source                           out_ch,
    input  logic                                cfg_wr_en,
    input  logic        [sts_pkg::THRESH_W-1:0] cfg_wr_data
);

    sts_pkg::sts_cmd_t    cmd;
    sts_pkg::sts_status_t status;

    // Sequencer and handshakes.
    sts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and result registers.
    sts_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .angle       (in_ch.angle),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sine        (out_ch.sine),
        .terms_used  (out_ch.terms_used),
        .truncated   (out_ch.truncated)
    );

endmodule
